// File: design/css_pkg.sv
// Shared types, codes and helpers for the CIGAR split segmenter.
package css_pkg;

    // CIGAR operation codes
    localparam logic [3:0] OP_M  = 4'd0;
    localparam logic [3:0] OP_I  = 4'd1;
    localparam logic [3:0] OP_D  = 4'd2;
    localparam logic [3:0] OP_N  = 4'd3;
    localparam logic [3:0] OP_S  = 4'd4;
    localparam logic [3:0] OP_EQ = 4'd7;
    localparam logic [3:0] OP_X  = 4'd8;

    // configuration register indexes
    localparam logic [1:0] CFG_MIN_SEG_LEN = 2'd0;
    localparam logic [1:0] CFG_EXCL_SCLIP  = 2'd1;

    localparam logic [15:0] MIN_SEG_LEN_RST = 16'd15;

    // result queue
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    typedef enum logic [1:0] {
        VERDICT_NONE     = 2'd0,
        VERDICT_OK       = 2'd1,
        VERDICT_SHORT    = 2'd2,
        VERDICT_MISMATCH = 2'd3
    } verdict_t;

    typedef struct packed {
        logic [31:0] read_start;
        logic [31:0] read_end;
        logic [31:0] ref_position;
        logic [7:0]  segment_index;
        logic        too_short;
        verdict_t    verdict;
        logic        last;
    } seg_result_t;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

// File: design/cigar_split_segmenter.sv
// Top level: CIGAR split segmenter with a small result queue.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  input   | s_valid/s_ready, s_op .. s_last_of_record | in
//  result  | m_valid/m_ready, m_read_start .. m_last   | out
//  config  | cfg_valid/cfg_ready, cfg_index, cfg_data  | in
//
// One CIGAR word is taken per cycle; its state update and up to two results
// are formed in the same cycle and pushed into a 4-entry result queue.
// Results leave one per cycle while m_ready is high, so a skip that is also last
// yields two result words. s_ready drops while the queue has fewer than two free slots.
// Synchronous active-low reset empties the queue and clears record state.
module cigar_split_segmenter
    import css_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_op,
    input  logic [27:0] s_op_length,
    input  logic        s_first_of_record,
    input  logic [30:0] s_ref_start,
    input  logic [7:0]  s_expected_segments,
    input  logic        s_last_of_record,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_read_start,
    output logic [31:0] m_read_end,
    output logic [31:0] m_ref_position,
    output logic [7:0]  m_segment_index,
    output logic        m_too_short,
    output logic [1:0]  m_verdict,
    output logic        m_last
);

    logic [15:0] min_len_reg;
    logic        excl_sclip_reg;

    logic [31:0] seg_start_reg, seg_end_reg, ref_pos_reg, ref_span_reg;
    logic        seg_open_reg, short_seen_reg;
    logic [7:0]  valid_count_reg, expected_count_reg;

    logic [31:0] seg_start_next, seg_end_next, ref_pos_next, ref_span_next;
    logic        seg_open_next, short_seen_next;
    logic [7:0]  valid_count_next, expected_count_next;

    // working values after first-of-record clearing
    logic [31:0] cur_start, cur_end, cur_ref, cur_span, op_len;
    logic        cur_open, cur_short;
    logic [7:0]  cur_count, cur_expected;

    logic        skip_emit, skip_is_short, fin_is_short;
    logic [7:0]  count_after_skip;
    logic        short_after_skip;
    seg_result_t skip_res, fin_res;

    seg_result_t res_q [RES_DEPTH];
    logic [RES_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [RES_CNT_W-1:0] count_reg, count_next;
    logic [1:0]           push_n;
    logic                 s_fire, m_fire;

    assign cfg_ready = 1'b1;
    assign s_ready   = (count_reg <= RES_CNT_W'(RES_DEPTH - 2));
    assign s_fire    = s_valid & s_ready;
    assign m_valid   = (count_reg != '0);
    assign m_fire    = m_valid & m_ready;
    assign op_len    = {4'd0, s_op_length};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_len_reg    <= MIN_SEG_LEN_RST;
            excl_sclip_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_MIN_SEG_LEN: min_len_reg    <= cfg_data;
                CFG_EXCL_SCLIP:  excl_sclip_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cur_start    = s_first_of_record ? 32'd0 : seg_start_reg;
        cur_end      = s_first_of_record ? 32'd0 : seg_end_reg;
        cur_ref      = s_first_of_record ? {1'b0, s_ref_start} : ref_pos_reg;
        cur_span     = s_first_of_record ? 32'd0 : ref_span_reg;
        cur_open     = s_first_of_record ? 1'b0 : seg_open_reg;
        cur_short    = s_first_of_record ? 1'b0 : short_seen_reg;
        cur_count    = s_first_of_record ? 8'd0 : valid_count_reg;
        cur_expected = s_first_of_record ? s_expected_segments : expected_count_reg;

        seg_start_next      = cur_start;
        seg_end_next        = cur_end;
        ref_pos_next        = cur_ref;
        ref_span_next       = cur_span;
        seg_open_next       = cur_open;
        expected_count_next = cur_expected;
        skip_emit           = 1'b0;

        unique case (s_op) inside
            OP_M, OP_EQ, OP_X: begin
                seg_end_next  = sat_add32(cur_end, op_len);
                ref_span_next = sat_add32(cur_span, op_len);
                seg_open_next = 1'b1;
            end
            OP_I: begin
                seg_end_next  = sat_add32(cur_end, op_len);
                seg_open_next = 1'b1;
            end
            OP_D: begin
                ref_span_next = sat_add32(cur_span, op_len);
                seg_open_next = 1'b1;
            end
            OP_S: begin
                if (!excl_sclip_reg) begin
                    seg_end_next  = sat_add32(cur_end, op_len);
                    seg_open_next = 1'b1;
                end else if (!cur_open) begin
                    // leading clip shifts the whole window
                    seg_start_next = sat_add32(cur_start, op_len);
                    seg_end_next   = sat_add32(cur_end, op_len);
                end
            end
            OP_N: begin
                if (cur_open) begin
                    skip_emit      = 1'b1;
                    ref_pos_next   = sat_add32(cur_ref, sat_add32(cur_span, op_len));
                    ref_span_next  = 32'd0;
                    seg_start_next = cur_end;
                    seg_open_next  = 1'b0;
                end
            end
            default: ;
        endcase

        // segment closed by the skip
        skip_is_short = (cur_end - cur_start) < {16'd0, min_len_reg};
        skip_res.read_start    = cur_start;
        skip_res.read_end      = cur_end;
        skip_res.ref_position  = cur_ref;
        skip_res.segment_index = cur_count;
        skip_res.too_short     = skip_is_short;
        skip_res.verdict       = VERDICT_NONE;
        skip_res.last          = 1'b0;

        count_after_skip = cur_count;
        short_after_skip = cur_short;
        if (skip_emit) begin
            if (skip_is_short)
                short_after_skip = 1'b1;
            else if (cur_count != 8'hFF)
                count_after_skip = cur_count + 8'd1;
        end

        // closing segment of the record
        fin_is_short = (seg_end_next - seg_start_next) < {16'd0, min_len_reg};
        valid_count_next = count_after_skip;
        short_seen_next  = short_after_skip;
        if (s_last_of_record) begin
            if (fin_is_short)
                short_seen_next = 1'b1;
            else if (count_after_skip != 8'hFF)
                valid_count_next = count_after_skip + 8'd1;
        end

        fin_res.read_start    = seg_start_next;
        fin_res.read_end      = seg_end_next;
        fin_res.ref_position  = ref_pos_next;
        fin_res.segment_index = count_after_skip;
        fin_res.too_short     = fin_is_short;
        fin_res.last          = 1'b1;
        if (short_seen_next)
            fin_res.verdict = VERDICT_SHORT;
        else if (valid_count_next != cur_expected)
            fin_res.verdict = VERDICT_MISMATCH;
        else
            fin_res.verdict = VERDICT_OK;

        push_n = s_fire ? ({1'b0, skip_emit} + {1'b0, s_last_of_record}) : 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_start_reg      <= '0;
            seg_end_reg        <= '0;
            ref_pos_reg        <= '0;
            ref_span_reg       <= '0;
            seg_open_reg       <= 1'b0;
            valid_count_reg    <= '0;
            short_seen_reg     <= 1'b0;
            expected_count_reg <= '0;
        end else if (s_fire) begin
            seg_start_reg      <= seg_start_next;
            seg_end_reg        <= seg_end_next;
            ref_pos_reg        <= ref_pos_next;
            ref_span_reg       <= ref_span_next;
            seg_open_reg       <= seg_open_next;
            valid_count_reg    <= valid_count_next;
            short_seen_reg     <= short_seen_next;
            expected_count_reg <= expected_count_next;
        end
    end

    // result queue: skip word first, then the closing word
    always_ff @(posedge aclk) begin
        if (push_n != 2'd0)
            res_q[wr_ptr_reg] <= skip_emit ? skip_res : fin_res;
        if (push_n == 2'd2)
            res_q[wr_ptr_reg + RES_PTR_W'(1)] <= fin_res;
    end

    assign count_next = count_reg + RES_CNT_W'(push_n) - RES_CNT_W'(m_fire);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + RES_PTR_W'(push_n);
            if (m_fire)
                rd_ptr_reg <= rd_ptr_reg + RES_PTR_W'(1);
            count_reg <= count_next;
        end
    end

    assign m_read_start    = res_q[rd_ptr_reg].read_start;
    assign m_read_end      = res_q[rd_ptr_reg].read_end;
    assign m_ref_position  = res_q[rd_ptr_reg].ref_position;
    assign m_segment_index = res_q[rd_ptr_reg].segment_index;
    assign m_too_short     = res_q[rd_ptr_reg].too_short;
    assign m_verdict       = res_q[rd_ptr_reg].verdict;
    assign m_last          = res_q[rd_ptr_reg].last;

endmodule

// File: design/css_checker.sv
// Port-level checks for the CIGAR split segmenter, bound to the top level.
module css_checker
    import css_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       s_last_of_record,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_too_short,
    input logic [1:0] m_verdict,
    input logic       m_last
);

    // a pending result word is not withdrawn
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word dropped while stalled");

    a_final_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> m_verdict != VERDICT_NONE)
        else $error("final word without verdict");

    a_mid_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> m_verdict == VERDICT_NONE)
        else $error("verdict on a non-final word");

    a_short_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last && m_too_short |-> m_verdict == VERDICT_SHORT)
        else $error("short closing segment not reported");

    // a record end always produces a result word right after
    a_last_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last_of_record |=> m_valid)
        else $error("record end produced no result");

endmodule

bind cigar_split_segmenter css_checker u_css_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .s_last_of_record (s_last_of_record),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_too_short      (m_too_short),
    .m_verdict        (m_verdict),
    .m_last           (m_last)
);

// File: dv/cigar_split_segmenter_test.sv
// Self-checking testbench for the CIGAR split segmenter: directed and random records.
module cigar_split_segmenter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import css_pkg::*;

    localparam logic [3:0] OP_H_CODE = 4'd5;
    localparam logic [3:0] OP_P_CODE = 4'd6;
    localparam int IDLE_SETTLE = 8;
    localparam int ITEM_TARGET = 1950;
    localparam int PHASES = 6;

    typedef struct packed {
        logic [3:0]  op;
        logic [27:0] op_length;
        logic        first_of_record;
        logic [30:0] ref_start;
        logic [7:0]  expected_segments;
        logic        last_of_record;
    } cigar_word_t;

    typedef enum int {RX_FREE, RX_COIN, RX_SPARSE} rx_mode_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [3:0]  s_op = '0;
    logic [27:0] s_op_length = '0;
    logic        s_first_of_record = 1'b0;
    logic [30:0] s_ref_start = '0;
    logic [7:0]  s_expected_segments = '0;
    logic        s_last_of_record = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_read_start;
    logic [31:0] m_read_end;
    logic [31:0] m_ref_position;
    logic [7:0]  m_segment_index;
    logic        m_too_short;
    logic [1:0]  m_verdict;
    logic        m_last;

    cigar_split_segmenter dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_op                (s_op),
        .s_op_length         (s_op_length),
        .s_first_of_record   (s_first_of_record),
        .s_ref_start         (s_ref_start),
        .s_expected_segments (s_expected_segments),
        .s_last_of_record    (s_last_of_record),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_read_start        (m_read_start),
        .m_read_end          (m_read_end),
        .m_ref_position      (m_ref_position),
        .m_segment_index     (m_segment_index),
        .m_too_short         (m_too_short),
        .m_verdict           (m_verdict),
        .m_last              (m_last)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // mirrored configuration
    logic [15:0] min_len_cfg = MIN_SEG_LEN_RST;
    logic        excl_sclip_cfg = 1'b0;

    // mirrored record state
    logic [31:0] win_start = '0;
    logic [31:0] win_end = '0;
    logic [31:0] ref_cursor = '0;
    logic [31:0] ref_consumed = '0;
    bit          seg_open = 1'b0;
    logic [7:0]  good_count = '0;
    bit          short_flag = 1'b0;
    logic [7:0]  declared_count = '0;

    seg_result_t pending_segments[$];
    int error_count = 0;
    int sent_items = 0;
    int burst_left = 0;

    rx_mode_t rx_mode = RX_FREE;
    int rx_left = 0;
    int rx_period = 2;
    int rx_tick = 0;

    function automatic logic [31:0] clamp_add(input logic [31:0] a, input logic [31:0] b);
        return (a > ~b) ? 32'hFFFF_FFFF : a + b;
    endfunction

    function automatic void emit_expected_segment(input bit is_closing);
        seg_result_t r;
        logic [31:0] span_len;
        span_len = win_end - win_start;
        r.read_start = win_start;
        r.read_end = win_end;
        r.ref_position = ref_cursor;
        r.segment_index = good_count;
        r.too_short = span_len < {16'd0, min_len_cfg};
        if (r.too_short)
            short_flag = 1'b1;
        else if (good_count != 8'hFF)
            good_count++;
        r.last = is_closing;
        if (!is_closing)
            r.verdict = VERDICT_NONE;
        else if (short_flag)
            r.verdict = VERDICT_SHORT;
        else if (good_count != declared_count)
            r.verdict = VERDICT_MISMATCH;
        else
            r.verdict = VERDICT_OK;
        pending_segments.insert(pending_segments.size(), r);
    endfunction

    function automatic void split_at_skips(input cigar_word_t w);
        logic [31:0] len;
        len = {4'd0, w.op_length};
        if (w.first_of_record) begin
            win_start = '0;
            win_end = '0;
            ref_cursor = {1'b0, w.ref_start};
            ref_consumed = '0;
            seg_open = 1'b0;
            good_count = '0;
            short_flag = 1'b0;
            declared_count = w.expected_segments;
        end
        case (w.op) inside
            OP_M, OP_EQ, OP_X: begin
                win_end = clamp_add(win_end, len);
                ref_consumed = clamp_add(ref_consumed, len);
                seg_open = 1'b1;
            end
            OP_I: begin
                win_end = clamp_add(win_end, len);
                seg_open = 1'b1;
            end
            OP_D: begin
                ref_consumed = clamp_add(ref_consumed, len);
                seg_open = 1'b1;
            end
            OP_S: begin
                if (!excl_sclip_cfg) begin
                    win_end = clamp_add(win_end, len);
                    seg_open = 1'b1;
                end else if (!seg_open) begin
                    // leading clip moves the whole window
                    win_start = clamp_add(win_start, len);
                    win_end = clamp_add(win_end, len);
                end
            end
            OP_N: begin
                if (seg_open) begin
                    emit_expected_segment(1'b0);
                    ref_cursor = clamp_add(ref_cursor, clamp_add(ref_consumed, len));
                    ref_consumed = '0;
                    win_start = win_end;
                    seg_open = 1'b0;
                end
            end
            default: ;
        endcase
        if (w.last_of_record)
            emit_expected_segment(1'b1);
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        seg_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_segments.size() == 0) begin
                $error("segment word with nothing expected");
                error_count++;
            end else begin
                want = pending_segments.pop_front();
                check_field("read_start", want.read_start, m_read_start);
                check_field("read_end", want.read_end, m_read_end);
                check_field("ref_position", want.ref_position, m_ref_position);
                check_field("segment_index", want.segment_index, m_segment_index);
                check_field("too_short", want.too_short, m_too_short);
                check_field("verdict", want.verdict, m_verdict);
                check_field("last", want.last, m_last);
            end
        end
    end

    // receiver: free-running, coin-flip and sparse stretches
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            rx_period = $urandom_range(2, 8);
            rx_left = $urandom_range(20, 200);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            RX_FREE: m_ready <= 1'b1;
            RX_COIN: m_ready <= 1'($urandom_range(0, 1));
            default: m_ready <= (rx_tick % rx_period == 0);
        endcase
    end

    task automatic send_word(input cigar_word_t w);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_op <= w.op;
        s_op_length <= w.op_length;
        s_first_of_record <= w.first_of_record;
        s_ref_start <= w.ref_start;
        s_expected_segments <= w.expected_segments;
        s_last_of_record <= w.last_of_record;
        do @(posedge aclk); while (!s_ready);
        split_at_skips(w);
        sent_items++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_segments.size() != 0) @(posedge aclk);
        repeat (IDLE_SETTLE) @(posedge aclk);
        burst_left = 0;
    endtask

    task automatic program_register(input logic [1:0] idx, input logic [15:0] data);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_MIN_SEG_LEN)
            min_len_cfg = data;
        else if (idx == CFG_EXCL_SCLIP)
            excl_sclip_cfg = data[0];
    endtask

    function automatic cigar_word_t cigar_word(input logic [3:0] op, input logic [27:0] len,
                                               input bit first_op, input bit last_op);
        cigar_word_t w;
        w.op = op;
        w.op_length = len;
        w.first_of_record = first_op;
        w.ref_start = 31'($urandom);
        w.expected_segments = 8'($urandom);
        w.last_of_record = last_op;
        return w;
    endfunction

    task automatic begin_record(input logic [3:0] op, input logic [27:0] len,
                                input logic [30:0] start, input logic [7:0] segs,
                                input bit last_op);
        cigar_word_t w;
        w = cigar_word(op, len, 1'b1, last_op);
        w.ref_start = start;
        w.expected_segments = segs;
        send_word(w);
    endtask

    task automatic push_op(input logic [3:0] op, input logic [27:0] len, input bit last_op);
        send_word(cigar_word(op, len, 1'b0, last_op));
    endtask

    function automatic logic [3:0] pick_op();
        int r;
        r = $urandom_range(0, 19);
        if (r < 5) return OP_M;
        else if (r == 5) return OP_EQ;
        else if (r == 6) return OP_X;
        else if (r < 9) return OP_I;
        else if (r < 11) return OP_D;
        else if (r < 15) return OP_N;
        else if (r < 17) return OP_S;
        else if (r == 17) return OP_H_CODE;
        else if (r == 18) return OP_P_CODE;
        else return OP_X + 4'($urandom_range(1, 7));
    endfunction

    function automatic logic [27:0] pick_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return 28'($urandom_range(0, 40));
        else if (r < 9) return 28'($urandom_range(0, 2000));
        else return 28'($urandom);
    endfunction

    // default config: every op, ignored codes, skips with and without an open segment
    task automatic test_directed_ops();
        push_op(OP_M, 28'd10, 1'b1);               // no record start: runs on reset state
        begin_record(OP_S, 28'd5, 31'h7FFF_FFFF, 8'd255, 1'b0);
        push_op(OP_M, 28'd20, 1'b0);
        push_op(OP_I, 28'd3, 1'b0);
        push_op(OP_D, 28'd4, 1'b0);
        push_op(OP_N, 28'd100, 1'b0);
        push_op(OP_EQ, 28'd7, 1'b0);
        push_op(OP_X, 28'd9, 1'b0);
        push_op(OP_H_CODE, 28'd3, 1'b0);
        push_op(OP_P_CODE, 28'd2, 1'b0);
        push_op(4'd15, 28'd9, 1'b0);
        push_op(OP_N, 28'd0, 1'b0);
        push_op(OP_N, 28'd50, 1'b0);               // nothing open: dropped
        push_op(OP_D, 28'd0, 1'b0);
        push_op(OP_N, 28'hFFF_FFFF, 1'b0);
        push_op(OP_S, 28'd2, 1'b1);
        begin_record(OP_M, 28'd30, 31'd0, 8'd1, 1'b0);
        push_op(OP_N, 28'd10, 1'b1);               // skip and close in one word
        begin_record(OP_D, 28'd0, 31'd1234, 8'd0, 1'b1);
        begin_record(OP_H_CODE, 28'd5, 31'd99, 8'd0, 1'b1);
    endtask

    task automatic test_soft_clip_excluded();
        program_register(CFG_EXCL_SCLIP, 16'd1);
        program_register(CFG_MIN_SEG_LEN, 16'd5);
        begin_record(OP_S, 28'd4, 31'd500, 8'd2, 1'b0);
        push_op(OP_S, 28'd3, 1'b0);
        push_op(OP_M, 28'd10, 1'b0);
        push_op(OP_S, 28'd6, 1'b0);                // inside the segment: no effect
        push_op(OP_N, 28'd2, 1'b0);
        push_op(OP_S, 28'd5, 1'b0);
        push_op(OP_I, 28'd8, 1'b0);
        push_op(OP_S, 28'd1, 1'b1);
    endtask

    task automatic test_position_saturation();
        program_register(CFG_EXCL_SCLIP, 16'd0);
        program_register(CFG_MIN_SEG_LEN, 16'd0);
        begin_record(OP_M, 28'hFFF_FFFF, 31'h7FFF_FFFF, 8'd2, 1'b0);
        repeat (17) push_op(OP_M, 28'hFFF_FFFF, 1'b0);
        push_op(OP_I, 28'hFFF_FFFF, 1'b0);
        push_op(OP_N, 28'hFFF_FFFF, 1'b0);
        push_op(OP_M, 28'd1, 1'b1);
    endtask

    // more than 255 valid segments in one record
    task automatic test_count_saturation();
        program_register(CFG_MIN_SEG_LEN, 16'd0);
        begin_record(OP_M, 28'd1, 31'd1000, 8'd255, 1'b0);
        for (int i = 0; i < 259; i++) begin
            push_op(OP_N, 28'd1, 1'b0);
            push_op(OP_M, 28'd1, i == 258);
        end
    endtask

    task automatic send_random_record();
        cigar_word_t rec[$];
        cigar_word_t w;
        int n_ops;
        int n_skips;
        n_ops = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        n_skips = 0;
        for (int i = 0; i < n_ops; i++) begin
            w = cigar_word(pick_op(), pick_len(), 1'b0, 1'b0);
            if (i == 0 && $urandom_range(0, 2) == 0)
                w.op = OP_S;
            if (w.op == OP_N)
                n_skips++;
            rec.insert(rec.size(), w);
        end
        // a few records lose their opening or closing flag
        rec[0].first_of_record = ($urandom_range(0, 19) != 0);
        rec[n_ops - 1].last_of_record = ($urandom_range(0, 19) != 0);
        case ($urandom_range(0, 9))
            0: rec[0].ref_start = 31'h7FFF_FFFF;
            1: rec[0].ref_start = 31'($urandom);
            default: rec[0].ref_start = 31'($urandom_range(0, 1000000));
        endcase
        if ($urandom_range(0, 2) != 0)
            rec[0].expected_segments = 8'(n_skips + 1);
        foreach (rec[i]) send_word(rec[i]);
    endtask

    task automatic test_random_traffic();
        logic [15:0] min_choices[PHASES] = '{16'd0, 16'hFFFF, 16'd15, 16'd1, 16'd30, 16'd0};
        int phase_end;
        for (int p = 0; p < PHASES; p++) begin
            if (p == PHASES - 1)
                min_choices[p] = 16'($urandom_range(0, 60));
            program_register(CFG_MIN_SEG_LEN, min_choices[p]);
            program_register(CFG_EXCL_SCLIP, 16'(p % 2));
            phase_end = sent_items + (ITEM_TARGET - sent_items) / (PHASES - p);
            while (sent_items < phase_end) begin
                if ($urandom_range(0, 9) == 0)
                    send_word(cigar_word(4'($urandom), pick_len(), 1'($urandom_range(0, 1)),
                                         1'($urandom_range(0, 1))));
                else
                    send_random_record();
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_ops();
        test_soft_clip_excluded();
        test_position_saturation();
        test_count_saturation();
        test_random_traffic();
        wait_idle();
        if (error_count == 0)
            $display("cigar_split_segmenter verification clean");
        else
            $display("cigar_split_segmenter verification failed");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("cigar_split_segmenter verification failed");
        $finish;
    end

endmodule

// File: cigar_split_segmenter.f
design/css_pkg.sv
design/cigar_split_segmenter.sv
design/css_checker.sv
dv/cigar_split_segmenter_test.sv
